// ===== src/prts_pkg.sv =====
// ----------------------------------------------------------------------------
// prts_pkg
// shared types, ring layout tables and constants for the priority ring stager
// ----------------------------------------------------------------------------
package prts_pkg;

  // field widths fixed by the request and result formats
  localparam int CH_W     = 3;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 8;
  localparam int MASK_W   = 7;
  localparam int PTR_W    = 3;
  localparam int CNT_W    = 4;
  localparam int DROP_W   = 32;

  // ring layout
  localparam int RING_SLOTS  = 8;
  localparam int STORE_DEPTH = 35;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int MAX_PACKET_LEN  = 244;
  localparam int DEF_NUM_RINGS   = 7;
  localparam int DEF_HANDLE_BITS = 32;

  localparam logic [CNT_W-1:0] MAX_DEPTH = 4'd8;

  // ring depths, powers of two (zero for the unused last slot) so a pointer wraps by masking
  localparam logic [CNT_W-1:0] DEPTH_OF [RING_SLOTS] =
    '{4'd4, 4'd2, 4'd8, 4'd8, 4'd1, 4'd8, 4'd4, 4'd0};

  // first descriptor slot of each ring
  localparam logic [ADDR_W-1:0] BASE_OF [RING_SLOTS] =
    '{6'd0, 6'd4, 6'd6, 6'd14, 6'd22, 6'd23, 6'd31, 6'd35};

  // the status ring overwrites without counting a drop
  localparam logic [RING_SLOTS-1:0] COUNTS_DROPS = 8'b1110_1111;

  typedef enum logic [1:0] {
    REQ_STAGE      = 2'd0,
    REQ_POP        = 2'd1,
    REQ_PUSH_FRONT = 2'd2,
    REQ_FLUSH      = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t             req_type;
    logic [CH_W-1:0]       channel;
    logic [HANDLE_W-1:0]   packet_handle;
    logic [LEN_W-1:0]      length;
    logic                  link_up;
    logic [MASK_W-1:0]     ready_mask;
  } in_t;

  typedef struct packed {
    logic                  accepted;
    logic [CH_W-1:0]       out_channel;
    logic [HANDLE_W-1:0]   out_handle;
    logic [LEN_W-1:0]      out_length;
    logic                  evicted;
    logic [DROP_W-1:0]     drop_total;
    logic [CNT_W-1:0]      high_water;
  } out_t;

  // result of one request before the descriptor read data joins it
  typedef struct packed {
    logic                  accepted;
    logic [CH_W-1:0]       out_channel;
    logic                  evicted;
    logic                  popped;
    logic [DROP_W-1:0]     drop_total;
    logic [CNT_W-1:0]      high_water;
  } res_t;

  // descriptor memory command
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_cmd_t;

endpackage

// ===== src/prts_desc_mem.sv =====
// ----------------------------------------------------------------------------
// prts_desc_mem
// descriptor store for all rings, one write and one registered read port
// ----------------------------------------------------------------------------
module prts_desc_mem #(
  parameter int WIDTH = prts_pkg::DEF_HANDLE_BITS + prts_pkg::LEN_W
) (
  input  logic                 clk,
  input  prts_pkg::mem_cmd_t   cmd,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);
  import prts_pkg::*;

  logic [WIDTH-1:0] mem_r [STORE_DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem_r[cmd.waddr] <= wdata;
    end
    if (cmd.re) begin
      rdata_r <= mem_r[cmd.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/prts_ring_ctrl.sv =====
// ----------------------------------------------------------------------------
// prts_ring_ctrl
// ring pointers and counters, request decode, drop counter and high-water mark
// ----------------------------------------------------------------------------
module prts_ring_ctrl #(
  parameter int NUM_RINGS   = prts_pkg::DEF_NUM_RINGS,
  parameter int HANDLE_BITS = prts_pkg::DEF_HANDLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  prts_pkg::in_t                         req,
  output prts_pkg::res_t                        res,
  output prts_pkg::mem_cmd_t                    cmd,
  output logic [HANDLE_BITS+prts_pkg::LEN_W-1:0] wdata
);
  import prts_pkg::*;

  logic [PTR_W-1:0]  head_r   [NUM_RINGS];
  logic [PTR_W-1:0]  head_nxt [NUM_RINGS];
  logic [CNT_W-1:0]  cnt_r    [NUM_RINGS];
  logic [CNT_W-1:0]  cnt_nxt  [NUM_RINGS];
  logic [DROP_W-1:0] drop_r, drop_nxt;
  logic [CNT_W-1:0]  peak_r, peak_nxt;

  // addressed ring
  logic [PTR_W-1:0]  sel_head;
  logic [CNT_W-1:0]  sel_cnt;
  logic              sel_ok;
  logic [CNT_W-1:0]  sel_depth;
  logic [PTR_W-1:0]  sel_mask;
  logic              sel_full;
  logic [ADDR_W-1:0] sel_base;
  logic              len_ok;

  // pop candidate
  logic              pop_found;
  logic [CH_W-1:0]   pop_ring;
  logic [PTR_W-1:0]  pop_head;
  logic [CNT_W-1:0]  pop_cnt;
  logic [PTR_W-1:0]  pop_mask;

  // update of one ring
  logic              upd;
  logic [CH_W-1:0]   upd_ring;
  logic [PTR_W-1:0]  new_head;
  logic [CNT_W-1:0]  new_cnt;
  logic              flush;

  logic              acc, ev, popped;
  logic              we;
  logic [ADDR_W-1:0] waddr;

  always_comb begin
    sel_head = '0;
    sel_cnt  = '0;
    sel_ok   = 1'b0;
    for (int i = 0; i < NUM_RINGS; i++) begin
      if (req.channel == CH_W'(i)) begin
        sel_head = head_r[i];
        sel_cnt  = cnt_r[i];
        sel_ok   = (DEPTH_OF[i] != '0);
      end
    end
  end

  assign sel_depth = DEPTH_OF[req.channel];
  assign sel_mask  = PTR_W'(sel_depth - 4'd1);
  assign sel_full  = (sel_cnt >= sel_depth);
  assign sel_base  = BASE_OF[req.channel];
  assign len_ok    = (req.length != '0) && (req.length <= LEN_W'(MAX_PACKET_LEN));

  // lowest numbered ring that holds data and may send
  always_comb begin
    pop_found = 1'b0;
    pop_ring  = '0;
    pop_head  = '0;
    pop_cnt   = '0;
    for (int i = 0; i < NUM_RINGS; i++) begin
      if (!pop_found && cnt_r[i] != '0 && req.ready_mask[i]) begin
        pop_found = 1'b1;
        pop_ring  = CH_W'(i);
        pop_head  = head_r[i];
        pop_cnt   = cnt_r[i];
      end
    end
  end

  assign pop_mask = PTR_W'(DEPTH_OF[pop_ring] - 4'd1);

  always_comb begin
    upd      = 1'b0;
    upd_ring = req.channel;
    new_head = sel_head;
    new_cnt  = sel_cnt;
    flush    = 1'b0;
    acc      = 1'b0;
    ev       = 1'b0;
    popped   = 1'b0;
    we       = 1'b0;
    waddr    = sel_base + ADDR_W'(sel_head);
    drop_nxt = drop_r;
    peak_nxt = peak_r;
    case (req.req_type)
      REQ_STAGE: begin
        if (sel_ok && len_ok && req.link_up) begin
          upd = 1'b1;
          acc = 1'b1;
          we  = 1'b1;
          if (sel_full) begin
            // oldest entry gives way, new one lands in its slot
            ev       = 1'b1;
            new_head = (sel_head + 3'd1) & sel_mask;
            new_cnt  = sel_cnt;
            if (COUNTS_DROPS[req.channel]) begin
              drop_nxt = drop_r + 32'd1;
            end
          end else begin
            waddr   = sel_base + ADDR_W'((sel_head + sel_cnt[PTR_W-1:0]) & sel_mask);
            new_cnt = sel_cnt + 4'd1;
          end
          if (new_cnt > peak_r) begin
            peak_nxt = new_cnt;
          end
        end
      end
      REQ_PUSH_FRONT: begin
        if (sel_ok && len_ok && !(sel_full && !COUNTS_DROPS[req.channel])) begin
          upd = 1'b1;
          acc = 1'b1;
          we  = 1'b1;
          if (sel_full) begin
            // head is evicted and replaced in place
            ev       = 1'b1;
            drop_nxt = drop_r + 32'd1;
          end else begin
            new_head = (sel_head - 3'd1) & sel_mask;
            waddr    = sel_base + ADDR_W'(new_head);
            new_cnt  = sel_cnt + 4'd1;
          end
        end
      end
      REQ_POP: begin
        if (pop_found) begin
          upd      = 1'b1;
          acc      = 1'b1;
          popped   = 1'b1;
          upd_ring = pop_ring;
          new_head = (pop_head + 3'd1) & pop_mask;
          new_cnt  = pop_cnt - 4'd1;
        end
      end
      REQ_FLUSH: begin
        flush = 1'b1;
        acc   = 1'b1;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_RINGS; i++) begin
      head_nxt[i] = head_r[i];
      cnt_nxt[i]  = cnt_r[i];
      if (flush) begin
        head_nxt[i] = '0;
        cnt_nxt[i]  = '0;
      end else if (upd && upd_ring == CH_W'(i)) begin
        head_nxt[i] = new_head;
        cnt_nxt[i]  = new_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      drop_r <= '0;
      peak_r <= '0;
    end else if (step) begin
      for (int i = 0; i < NUM_RINGS; i++) begin
        head_r[i] <= head_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
      drop_r <= drop_nxt;
      peak_r <= peak_nxt;
    end
  end

  assign cmd.we    = we && step;
  assign cmd.waddr = waddr;
  assign cmd.re    = step;
  assign cmd.raddr = BASE_OF[pop_ring] + ADDR_W'(pop_head);

  assign wdata = {req.length, req.packet_handle[HANDLE_BITS-1:0]};

  assign res.accepted    = acc;
  assign res.out_channel = popped ? pop_ring : '0;
  assign res.evicted     = ev;
  assign res.popped      = popped;
  assign res.drop_total  = drop_nxt;
  assign res.high_water  = peak_nxt;

endmodule

// ===== src/priority_multi_ring_tx_stager_top.sv =====
// ----------------------------------------------------------------------------
// priority_multi_ring_tx_stager_top
// seven transmit descriptor rings with strict drain priority, drop-oldest on
// full rings, push-front, flush, drop counter and high-water mark
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake              payload
//   in_*         in    in_valid / in_ready    in_data   (prts_pkg::in_t)
//   out_*        out   out_valid / out_ready  out_data  (prts_pkg::out_t)
//
// one request per cycle sustained while out_ready is high; a request is held
// in the request register, then the ring update and descriptor memory access
// land in the result register, from which the result is offered; the result
// register stage is set by the single write / registered read descriptor memory
// rst_n (synchronous) clears ring pointers, counts, drop counter and peak;
// descriptor memory is not cleared and needs no clearing pass
// while out_ready is low the result holds and the request register holds;
// one more request is still taken while the result waits
//
module priority_multi_ring_tx_stager_top #(
  parameter int NUM_RINGS   = prts_pkg::DEF_NUM_RINGS,
  parameter int HANDLE_BITS = prts_pkg::DEF_HANDLE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  prts_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output prts_pkg::out_t  out_data
);
  import prts_pkg::*;

  localparam int ENTRY_W = HANDLE_BITS + LEN_W;

  // request register
  logic     a_valid_r, a_valid_nxt;
  in_t      a_data_r;

  // result register (descriptor read data registered inside the memory)
  logic     b_valid_r, b_valid_nxt;
  res_t     b_res_r;

  logic     in_fire;
  logic     load_b;

  res_t                 res;
  mem_cmd_t             cmd;
  logic [ENTRY_W-1:0]   wdata;
  logic [ENTRY_W-1:0]   rdata;

  // request moves on when the result register is empty or being drained
  assign load_b   = a_valid_r && (!b_valid_r || out_ready);
  assign in_ready = !a_valid_r || load_b;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_fire) begin
      a_valid_nxt = 1'b1;
    end else if (load_b) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (load_b) begin
      b_valid_nxt = 1'b1;
    end else if (out_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_data_r <= in_data;
    end
    if (load_b) begin
      b_res_r <= res;
    end
  end

  // ring state, decode and counters
  prts_ring_ctrl #(
    .NUM_RINGS   (NUM_RINGS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (load_b),
    .req   (a_data_r),
    .res   (res),
    .cmd   (cmd),
    .wdata (wdata)
  );

  // descriptor store, read data arrives with the result register
  prts_desc_mem #(
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .cmd   (cmd),
    .wdata (wdata),
    .rdata (rdata)
  );

  // popped descriptor fields only on a successful pop
  assign out_valid            = b_valid_r;
  assign out_data.accepted    = b_res_r.accepted;
  assign out_data.out_channel = b_res_r.out_channel;
  assign out_data.out_handle  = b_res_r.popped ? HANDLE_W'(rdata[HANDLE_BITS-1:0]) : '0;
  assign out_data.out_length  = b_res_r.popped ? rdata[ENTRY_W-1:HANDLE_BITS] : '0;
  assign out_data.evicted     = b_res_r.evicted;
  assign out_data.drop_total  = b_res_r.drop_total;
  assign out_data.high_water  = b_res_r.high_water;

  // an eviction only ever comes with a request that took effect
  a_evict_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.evicted |-> out_data.accepted)
    else $error("eviction reported on a request that did not take effect");

  // popped descriptors were staged with a checked length
  a_pop_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && b_res_r.popped |->
      out_data.out_length != '0 && out_data.out_length <= LEN_W'(MAX_PACKET_LEN))
    else $error("popped descriptor with a length outside the valid range");

  // occupancy never exceeds the deepest ring
  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.high_water <= MAX_DEPTH)
    else $error("high-water mark above the deepest ring");

  // one request adds at most one drop
  a_drop_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 out_valid |->
      (out_data.drop_total - $past(out_data.drop_total)) <= 32'd1)
    else $error("drop counter moved by more than one between results");

endmodule

// ===== verif/prts_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prts_checker
// watches the request and result channels of the ring stager, keeps its own copy of the
// seven rings, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module prts_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  prts_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  prts_pkg::out_t out_data,
  output int             fail_count,
  output int             pending,
  output int             results_seen,
  output int             pop_hits,
  output int             evictions
);
  import prts_pkg::*;

  localparam int NRINGS      = 7;
  localparam int SLOTS       = 8;
  localparam int LEN_LIMIT   = 244;
  localparam int STATUS_RING = 4;

  typedef struct packed {
    logic [7:0]  len;
    logic [31:0] handle;
  } desc_t;

  desc_t       ring_slot [NRINGS][SLOTS];
  int          ring_head [NRINGS];
  int          ring_fill [NRINGS];
  logic [31:0] drop_tally;
  logic [3:0]  fill_peak;
  out_t        expected_q [$];

  int fail_tally   = 0;
  int backlog      = 0;
  int result_tally = 0;
  int pop_tally    = 0;
  int evict_tally  = 0;

  assign fail_count   = fail_tally;
  assign pending      = backlog;
  assign results_seen = result_tally;
  assign pop_hits     = pop_tally;
  assign evictions    = evict_tally;

  function automatic int ring_depth(int ch);
    case (ch)
      0:       return 4;
      1:       return 2;
      2, 3, 5: return 8;
      4:       return 1;
      6:       return 4;
      default: return 0;
    endcase
  endfunction

  // oldest entry leaves the ring
  function automatic void retire_head(int ch);
    ring_head[ch] = (ring_head[ch] + 1) % ring_depth(ch);
    ring_fill[ch]--;
  endfunction

  function automatic out_t predict_result(in_t r);
    out_t res;
    int   ch;
    int   d;
    int   pos;
    bit   len_ok;
    bit   found;
    bit   room;
    desc_t e;
    res    = '0;
    ch     = int'(r.channel);
    len_ok = (r.length != 0) && (int'(r.length) <= LEN_LIMIT);
    found  = 1'b0;
    room   = 1'b1;
    case (r.req_type)
      REQ_STAGE: begin
        if (ch < NRINGS && len_ok && r.link_up) begin
          d = ring_depth(ch);
          if (ring_fill[ch] >= d) begin
            retire_head(ch);
            res.evicted = 1'b1;
            // status ring overwrites without counting a drop
            if (ch != STATUS_RING) drop_tally++;
          end
          pos = (ring_head[ch] + ring_fill[ch]) % d;
          ring_slot[ch][pos] = {r.length, r.packet_handle};
          ring_fill[ch]++;
          if (ring_fill[ch] > int'(fill_peak)) fill_peak = 4'(ring_fill[ch]);
          res.accepted = 1'b1;
        end
      end
      REQ_POP: begin
        for (int i = 0; i < NRINGS; i++) begin
          if (!found && ring_fill[i] > 0 && r.ready_mask[i]) begin
            e = ring_slot[i][ring_head[i]];
            res.accepted    = 1'b1;
            res.out_channel = 3'(i);
            res.out_handle  = e.handle;
            res.out_length  = e.len;
            retire_head(i);
            found = 1'b1;
          end
        end
        if (found) pop_tally++;
      end
      REQ_PUSH_FRONT: begin
        if (ch < NRINGS && len_ok) begin
          d = ring_depth(ch);
          if (ring_fill[ch] >= d) begin
            if (ch == STATUS_RING) begin
              room = 1'b0;
            end else begin
              retire_head(ch);
              drop_tally++;
              res.evicted = 1'b1;
            end
          end
          if (room) begin
            ring_head[ch] = (ring_head[ch] + d - 1) % d;
            ring_slot[ch][ring_head[ch]] = {r.length, r.packet_handle};
            ring_fill[ch]++;
            res.accepted = 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < NRINGS; i++) begin
          ring_head[i] = 0;
          ring_fill[i] = 0;
        end
        res.accepted = 1'b1;
      end
    endcase
    if (res.evicted) evict_tally++;
    res.drop_total = drop_tally;
    res.high_water = fill_peak;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t  mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      for (int i = 0; i < NRINGS; i++) begin
        ring_head[i] = 0;
        ring_fill[i] = 0;
      end
      drop_tally = '0;
      fill_peak  = '0;
      expected_q.delete();
      backlog <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_tally++;
        if (expected_q.size() == 0) begin
          report_mismatch("result with no request outstanding", out_data.out_handle, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.accepted !== want.accepted)
            report_mismatch("accepted", 32'(out_data.accepted), 32'(want.accepted));
          if (out_data.out_channel !== want.out_channel)
            report_mismatch("out_channel", 32'(out_data.out_channel), 32'(want.out_channel));
          if (out_data.out_handle !== want.out_handle)
            report_mismatch("out_handle", out_data.out_handle, want.out_handle);
          if (out_data.out_length !== want.out_length)
            report_mismatch("out_length", 32'(out_data.out_length), 32'(want.out_length));
          if (out_data.evicted !== want.evicted)
            report_mismatch("evicted", 32'(out_data.evicted), 32'(want.evicted));
          if (out_data.drop_total !== want.drop_total)
            report_mismatch("drop_total", out_data.drop_total, want.drop_total);
          if (out_data.high_water !== want.high_water)
            report_mismatch("high_water", 32'(out_data.high_water), 32'(want.high_water));
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_result(in_data));
      backlog <= expected_q.size();
    end
  end

endmodule

// ===== verif/tb_priority_multi_ring_tx_stager_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_multi_ring_tx_stager_top
// drives directed and random stage, pop, push-front and flush requests into
// the ring stager with random idling on both sides; the checker predicts and
// compares every result, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_priority_multi_ring_tx_stager_top;
  import prts_pkg::*;

  // random part of the run and the watchdog
  localparam int RANDOM_REQUESTS = 1330;
  localparam int CYCLE_LIMIT     = 400000;
  // length of the receiver's long hold-off, well past what the block buffers
  localparam int HOLD_CYCLES     = 120;
  localparam int MAX_GAP         = 13;
  // cycles allowed after the last result for any stray one to show up
  localparam int SETTLE_CYCLES   = 8;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  in_t  in_data   = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  int fail_count;
  int pending;
  int results_seen;
  int pop_hits;
  int evictions;
  int sent = 0;

  priority_multi_ring_tx_stager_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  prts_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .pop_hits     (pop_hits),
    .evictions    (evictions)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    int cycles;
    cycles = 0;
    do begin
      @(posedge clk);
      cycles++;
    end while (cycles < CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("[priority_multi_ring_tx_stager_top] ERROR");
    $finish;
  end

  function automatic in_t mk(req_type_t kind, int ch, logic [31:0] handle, int len,
                             bit link, logic [6:0] mask);
    in_t r;
    r.req_type      = kind;
    r.channel       = 3'(ch);
    r.packet_handle = handle;
    r.length        = 8'(len);
    r.link_up       = link;
    r.ready_mask    = mask;
    return r;
  endfunction

  // mostly well-formed requests with random content, some noise mixed in
  function automatic in_t random_request();
    in_t r;
    int  pick;
    pick = $urandom_range(0, 99);
    // stages outnumber pops so rings fill and start dropping
    if (pick < 46)      r.req_type = REQ_STAGE;
    else if (pick < 80) r.req_type = REQ_POP;
    else if (pick < 97) r.req_type = REQ_PUSH_FRONT;
    else                r.req_type = REQ_FLUSH;
    // an out-of-range channel now and then
    if ($urandom_range(0, 15) == 0) r.channel = 3'd7;
    else                            r.channel = 3'($urandom_range(0, 6));
    r.packet_handle = $urandom();
    pick = $urandom_range(0, 19);
    case (pick)
      0:       r.length = 8'd0;
      1:       r.length = 8'($urandom_range(245, 255));
      2:       r.length = 8'd244;
      3:       r.length = 8'd1;
      default: r.length = 8'($urandom_range(1, 244));
    endcase
    r.link_up = ($urandom_range(0, 15) != 0);
    pick = $urandom_range(0, 9);
    if (pick == 0)      r.ready_mask = 7'h00;
    else if (pick == 1) r.ready_mask = 7'h7f;
    else                r.ready_mask = 7'($urandom_range(0, 127));
    return r;
  endfunction

  // offer one request after a random gap and hold it until taken;
  // every third stretch of 80 requests goes back to back
  task automatic send_request(input in_t req);
    int gap;
    gap = ((sent / 80) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // stop offering until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: random stall per result, stretches with no stall, and two long
  // hold-offs while the sender keeps going so the block backs up
  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 200 || taken == 700) gap = HOLD_CYCLES;
      else if ((taken / 64) % 3 == 1)   gap = 0;
      else                              gap = $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening: empty pop, field extremes, ignored requests
    send_request(mk(REQ_POP,        0, 32'h0,        0,   1'b1, 7'h7f));
    send_request(mk(REQ_STAGE,      0, 32'h0,        1,   1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      0, 32'hffffffff, 244, 1'b1, 7'h7f));
    // bad lengths, link down and out-of-range channel are all ignored
    send_request(mk(REQ_STAGE,      0, 32'h11111111, 0,   1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      0, 32'h22222222, 245, 1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      0, 32'h33333333, 255, 1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      2, 32'h44444444, 10,  1'b0, 7'h00));
    send_request(mk(REQ_STAGE,      7, 32'h55555555, 10,  1'b1, 7'h00));
    send_request(mk(REQ_PUSH_FRONT, 7, 32'h66666666, 10,  1'b1, 7'h00));
    // status ring: overwrite on stage is not a drop, push-front onto full discards
    send_request(mk(REQ_STAGE,      4, 32'haaaa0001, 20,  1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      4, 32'haaaa0002, 21,  1'b1, 7'h00));
    send_request(mk(REQ_PUSH_FRONT, 4, 32'haaaa0003, 22,  1'b1, 7'h00));
    // two-deep ring overflows on stage, then on push-front
    send_request(mk(REQ_STAGE,      1, 32'hbbbb0001, 30,  1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      1, 32'hbbbb0002, 31,  1'b1, 7'h00));
    send_request(mk(REQ_STAGE,      1, 32'hbbbb0003, 32,  1'b1, 7'h00));
    send_request(mk(REQ_PUSH_FRONT, 1, 32'hbbbb0004, 33,  1'b0, 7'h00));
    // push-front ignores the link, but not a zero length
    send_request(mk(REQ_PUSH_FRONT, 2, 32'hcccc0001, 100, 1'b0, 7'h00));
    send_request(mk(REQ_PUSH_FRONT, 3, 32'hcccc0002, 0,   1'b1, 7'h00));
    // pops: nothing ready, only the status ring ready, an empty ring ready, all
    send_request(mk(REQ_POP,        0, 32'h0,        0,   1'b1, 7'h00));
    send_request(mk(REQ_POP,        0, 32'h0,        0,   1'b1, 7'h10));
    send_request(mk(REQ_POP,        0, 32'h0,        0,   1'b1, 7'h40));
    send_request(mk(REQ_POP,        0, 32'h0,        0,   1'b1, 7'h7f));
    send_request(mk(REQ_STAGE,      6, 32'h5a5a5a5a, 200, 1'b1, 7'h00));
    // flush keeps drop count and peak, then nothing is left to pop
    send_request(mk(REQ_FLUSH,      0, 32'h0,        0,   1'b0, 7'h00));
    send_request(mk(REQ_POP,        0, 32'h0,        0,   1'b1, 7'h7f));
    wait_drained();

    // random part, with two full drains part way through
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 500 || n == 1000) wait_drained();
      send_request(random_request());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d requests and %0d checked results", sent, results_seen);
    $display("%0d pops served a descriptor, %0d requests evicted an entry",
             pop_hits, evictions);
    if (fail_count == 0 && pending == 0) begin
      $display("[priority_multi_ring_tx_stager_top] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("[priority_multi_ring_tx_stager_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== priority_multi_ring_tx_stager_top.f =====
src/prts_pkg.sv
src/prts_desc_mem.sv
src/prts_ring_ctrl.sv
src/priority_multi_ring_tx_stager_top.sv
verif/prts_checker.sv
verif/tb_priority_multi_ring_tx_stager_top.sv
